// ===== rtl/sliding_frame_synchronizer_macros.svh =====
// Assertion helpers shared by the frame synchronizer modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef SLIDING_FRAME_SYNCHRONIZER_MACROS_SVH
`define SLIDING_FRAME_SYNCHRONIZER_MACROS_SVH

// Same-cycle implication.
`define SFS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sfs_pkg.sv =====
package sfs_pkg;

   localparam int BYTE_W = 8;
   localparam int ADDR_W = 24;
   localparam int IDX_W  = 6;
   localparam int WORD_W = 32;

   // Frame layout: sync, three address bytes, one ignored byte, payload, checksum.
   localparam int ADDR_OFF    = 1;
   localparam int PAYLOAD_OFF = 5;

   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'd55;

   typedef struct packed {
      logic [ADDR_W-1:0] target_address;
      logic [IDX_W-1:0]  word_index;
      logic [WORD_W-1:0] payload_word;
      logic              last_word;
   } word_entry_type;

endpackage

// ===== rtl/sfs_front.sv =====
`include "sliding_frame_synchronizer_macros.svh"

module sfs_front #(
   parameter int PAYLOAD_WORDS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sfs_pkg::BYTE_W-1:0]   req_rx_byte,
   input  logic                         csr_we,
   input  logic [sfs_pkg::BYTE_W-1:0]   csr_wdata,
   output logic                         q_push,
   output sfs_pkg::word_entry_type      q_entry,
   input  logic                         q_full
);
   import sfs_pkg::*;

   localparam int FRAME_LEN = 4 * PAYLOAD_WORDS + 6;
   localparam int PTR_W     = $clog2(FRAME_LEN);
   localparam logic [PTR_W-1:0] LAST_POS   = PTR_W'(FRAME_LEN - 1);
   localparam logic [PTR_W-1:0] LAST_OFF   = PTR_W'(FRAME_LEN - 2);
   localparam logic [PTR_W-1:0] ONE        = PTR_W'(1);
   localparam logic [PTR_W-1:0] ADDR_B0    = PTR_W'(ADDR_OFF);
   localparam logic [PTR_W-1:0] ADDR_B1    = PTR_W'(ADDR_OFF + 1);
   localparam logic [PTR_W-1:0] ADDR_B2    = PTR_W'(ADDR_OFF + 2);
   localparam logic [PTR_W-1:0] PAY_START  = PTR_W'(PAYLOAD_OFF);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT
   } state_type;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
      logic [PTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PTR_W+1)'(FRAME_LEN)) begin
         s = s - (PTR_W+1)'(FRAME_LEN);
      end
      return s[PTR_W-1:0];
   endfunction

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    fill_ff, fill_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]   sync_ff, sync_in;
   logic                pend_ff, pend_in;
   logic [PTR_W-1:0]    iss_ff, iss_in;
   logic [PTR_W-1:0]    cur_ff, cur_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [23:0]         lanes_ff, lanes_in;

   logic [BYTE_W-1:0]   window_mem [FRAME_LEN];
   logic [BYTE_W-1:0]   rd_data_ff;
   logic                rd_en, wr_en;
   logic [PTR_W-1:0]    rd_addr, wr_addr;

   logic                accept, full_now, pass;
   logic [PTR_W-1:0]    cur_pay;
   logic [1:0]          lane;
   logic                word_done, stall;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign full_now  = (fill_ff == LAST_POS);
   assign pass      = (rd_data_ff == sync_ff) && (sum_ff == byte_ff);

   assign cur_pay   = cur_ff - PAY_START;
   assign lane      = cur_pay[1:0];
   assign word_done = pend_ff && (cur_ff >= PAY_START) && (lane == 2'd3);
   assign stall     = word_done && q_full;
   assign q_push    = (state_ff == ST_EMIT) && word_done && !q_full;

   always_comb begin
      q_entry.target_address = addr_ff;
      q_entry.word_index     = IDX_W'(cur_pay >> 2);
      q_entry.payload_word   = {rd_data_ff, lanes_ff};
      q_entry.last_word      = (cur_ff == LAST_OFF);
   end

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      pend_in  = pend_ff;
      iss_in   = iss_ff;
      cur_in   = cur_ff;
      byte_in  = byte_ff;
      addr_in  = addr_ff;
      lanes_in = lanes_ff;
      sync_in  = csr_we ? csr_wdata : sync_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;
      wr_en    = 1'b0;
      wr_addr  = wrap_add(head_ff, fill_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // store the byte, fetch the oldest one for the check
               wr_en   = 1'b1;
               rd_en   = 1'b1;
               byte_in = req_rx_byte;
               if (full_now) begin
                  state_in = ST_CHECK;
               end else begin
                  fill_in = fill_ff + ONE;
                  sum_in  = sum_ff + req_rx_byte;
               end
            end
         end
         ST_CHECK: begin
            if (pass) begin
               state_in = ST_EMIT;
               fill_in  = '0;
               sum_in   = '0;
               iss_in   = ADDR_B0;
               pend_in  = 1'b0;
            end else begin
               // drop the oldest byte, keep the new one in the running sum
               head_in  = wrap_add(head_ff, ONE);
               sum_in   = sum_ff + byte_ff - rd_data_ff;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!stall) begin
               if (pend_ff) begin
                  if (cur_ff == ADDR_B0) begin
                     addr_in[7:0] = rd_data_ff;
                  end else if (cur_ff == ADDR_B1) begin
                     addr_in[15:8] = rd_data_ff;
                  end else if (cur_ff == ADDR_B2) begin
                     addr_in[23:16] = rd_data_ff;
                  end else if (cur_ff >= PAY_START) begin
                     unique case (lane)
                        2'd0: lanes_in[7:0]   = rd_data_ff;
                        2'd1: lanes_in[15:8]  = rd_data_ff;
                        2'd2: lanes_in[23:16] = rd_data_ff;
                        2'd3: lanes_in        = lanes_ff;
                     endcase
                     if (cur_ff == LAST_OFF) begin
                        state_in = ST_IDLE;
                     end
                  end
               end
               if (iss_ff <= LAST_OFF) begin
                  rd_en   = 1'b1;
                  rd_addr = wrap_add(head_ff, iss_ff);
                  cur_in  = iss_ff;
                  iss_in  = iss_ff + ONE;
                  pend_in = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         sync_ff  <= SYNC_RESET;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         sync_ff  <= sync_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff   <= iss_in;
      cur_ff   <= cur_in;
      byte_ff  <= byte_in;
      addr_ff  <= addr_in;
      lanes_ff <= lanes_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         window_mem[wr_addr] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= window_mem[rd_addr];
      end
   end

   `SFS_ASSERT_IMPLY(a_no_overflow, q_push, !q_full, "word pushed into a full queue")
   `SFS_ASSERT_IMPLY(a_fill_range, 1'b1, fill_ff <= LAST_POS, "fill count past window length")
   `SFS_ASSERT_NEXT(a_last_ends, q_push && q_entry.last_word, state_ff == ST_IDLE,
                    "emission did not end after last word")

endmodule

// ===== rtl/sfs_back.sv =====
`include "sliding_frame_synchronizer_macros.svh"

module sfs_back #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  sfs_pkg::word_entry_type      push_entry,
   output logic                         full,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sfs_pkg::word_entry_type      rsp_entry
);
   import sfs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   word_entry_type    q_mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;

   assign full      = (count_ff == CNT_FULL);
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_entry = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push_valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         q_mem[wr_ptr_ff] <= push_entry;
      end
   end

   `SFS_ASSERT_IMPLY(a_count_range, 1'b1, count_ff <= CNT_FULL, "queue count past depth")
   `SFS_ASSERT_NEXT(a_pop_drains, pop && !push_valid, count_ff == $past(count_ff) - CNT_W'(1),
                    "pop without push did not drain one entry")
   `SFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry),
                    "waiting word changed or dropped before its transfer")

endmodule

// ===== rtl/sliding_frame_synchronizer.sv =====
// A passing frame's first word is queued after the check state and the reads of its address,
//   ignored and first four payload bytes. Throughput: 1 byte/cycle while the window fills; once
//   full, each byte is followed by a check state (one window read) before the next is taken.
// Emission: single read port, four bytes per payload word, stalls on a full queue, takes no byte.
// Reset: synchronous, active high; empties the window and queue, sync byte returns to 55.
module sliding_frame_synchronizer #(
   parameter int PAYLOAD_WORDS = 32,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   // byte input channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sfs_pkg::BYTE_W-1:0]   req_rx_byte,
   // payload word output channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sfs_pkg::ADDR_W-1:0]   rsp_target_address,
   output logic [sfs_pkg::IDX_W-1:0]    rsp_word_index,
   output logic [sfs_pkg::WORD_W-1:0]   rsp_payload_word,
   output logic                         rsp_last_word,
   // sync byte register
   input  logic                         csr_we,
   input  logic [sfs_pkg::BYTE_W-1:0]   csr_wdata
);
   import sfs_pkg::*;

   // Front/back hand-off: one word per transfer into the queue.
   logic           q_push;
   logic           q_full;
   word_entry_type q_entry;
   word_entry_type rsp_entry;

   // Front: holds the sliding window in a circular buffer with a running byte sum.
   // Each byte is written at head+fill; once the window is full, the oldest byte is
   // read back and compared with the sync byte while the running sum is compared
   // with the newest byte. On a miss, advance head, drop the oldest byte from
   // the sum and add the newest. On a hit, empty the window and walk its address
   // and payload bytes, packing four at a time into words.
   sfs_front #(
      .PAYLOAD_WORDS (PAYLOAD_WORDS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .q_push      (q_push),
      .q_entry     (q_entry),
      .q_full      (q_full)
   );

   // Back: short word queue whose head drives the result ports from registers,
   // so a stalled consumer only holds the front once the queue fills.
   sfs_back #(
      .DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_entry  (rsp_entry)
   );

   assign rsp_target_address = rsp_entry.target_address;
   assign rsp_word_index     = rsp_entry.word_index;
   assign rsp_payload_word   = rsp_entry.payload_word;
   assign rsp_last_word      = rsp_entry.last_word;

endmodule
